FILE: sv/bei_pkg.sv
// ----------------------------------------------------------------------------
// bei_pkg: shared types and constants for the biomorph escape iterator
// Field widths, fixed-point format, register indexes, controller states and
// the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bei_pkg;

    // fixed-point format
    localparam int FRAC_BITS  = 28;
    localparam int COUNT_BITS = 16;
    localparam int IN_W       = 32;               // point and Julia constant
    localparam int THR_W      = 32;               // unsigned threshold
    localparam int Z_BITS     = 40;               // internal z, signed Q12.28
    localparam int HALF       = Z_BITS / 2;       // multiplier operand split
    localparam int PP_W       = Z_BITS + HALF;    // partial product width
    localparam int PROD_W     = 2 * Z_BITS;       // full product width
    localparam int SUM_W      = Z_BITS + 3;       // pre-saturation sum width
    localparam int CFG_W      = 32;               // config data width
    localparam int ADDR_W     = 3;

    // reset values
    localparam logic [THR_W-1:0]      THR_RESET  = 32'hA000_0000;  // 10.0
    localparam logic [COUNT_BITS-1:0] ITER_RESET = COUNT_BITS'(256);

    // square product cap, 1.0 at Z_BITS above the binary point of the shift
    localparam logic [PROD_W-1:0] PROD_CAP = PROD_W'(1) << Z_BITS;

    // register indexes
    localparam logic [ADDR_W-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [ADDR_W-1:0] REG_MAX_ITER  = 3'd1;
    localparam logic [ADDR_W-1:0] REG_JULIA_EN  = 3'd2;
    localparam logic [ADDR_W-1:0] REG_JULIA_RE  = 3'd3;
    localparam logic [ADDR_W-1:0] REG_JULIA_IM  = 3'd4;

    typedef struct packed {
        logic signed [IN_W-1:0] c_re;
        logic signed [IN_W-1:0] c_im;
    } in_item_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] escape_count;
        logic                  escaped;
    } out_item_t;

    typedef struct packed {
        logic [THR_W-1:0]      threshold;
        logic [COUNT_BITS-1:0] max_iter;
        logic                  julia_mode;
        logic [IN_W-1:0]       julia_c_re;
        logic [IN_W-1:0]       julia_c_im;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ACC,
        ST_UPD,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture request, set up z and constant
        logic mul_lo;   // partial products on low operand half
        logic mul_hi;   // partial products on high operand half
        logic acc;      // combine, shift and cap products
        logic upd;      // new z, escape test, counter step
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic zero_lim; // iteration limit is zero
        logic finish;   // valid in update: escaped or last iteration
    } stat_t;

endpackage

FILE: sv/bei_ctrl.sv
// ----------------------------------------------------------------------------
// bei_ctrl: iteration sequencer
// Four-step iteration loop (low products, high products, accumulate, update)
// and hand-off of the finished result to the output register.
// ----------------------------------------------------------------------------
module bei_ctrl
    import bei_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_ready,
    input  logic  out_free,
    output logic  push,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        push       = 1'b0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.zero_lim ? ST_DONE : ST_MUL_LO;
                end
            end
            ST_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = stat.finish ? ST_DONE : ST_MUL_LO;
            end
            ST_DONE:
            begin
                // wait for a free output slot
                if (out_free)
                begin
                    push       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/bei_dpath.sv
// ----------------------------------------------------------------------------
// bei_dpath: complex squaring datapath
// Holds z, the iteration constant and counter; forms |x|^2, |y|^2, 2|x||y|
// with 40x20 multipliers over the low and high operand halves, then saturates and tests escape.
// ----------------------------------------------------------------------------
module bei_dpath
    import bei_pkg::*;
(
    input  logic      clk,
    input  cmd_t      cmd,
    input  cfg_t      cfg,
    input  in_item_t  req,
    output stat_t     stat,
    output out_item_t result
);

    logic [Z_BITS-1:0]     z_re_reg, z_im_reg;
    logic [IN_W-1:0]       k_re_reg, k_im_reg;
    logic [COUNT_BITS-1:0] iter_reg;
    logic [PP_W-1:0]       plo_xx_reg, plo_yy_reg, plo_xy_reg;
    logic [PP_W-1:0]       phi_xx_reg, phi_yy_reg, phi_xy_reg;
    logic [Z_BITS:0]       sq_xx_reg, sq_yy_reg, sq_xy_reg;
    logic [COUNT_BITS-1:0] res_count_reg;
    logic                  res_esc_reg;

    logic [Z_BITS-1:0]     ax, ay;
    logic [HALF-1:0]       bx, by;
    logic [PP_W-1:0]       m_xx, m_yy, m_xy;
    logic [PROD_W-1:0]     full_xx, full_yy, full_xy;
    logic [SUM_W-1:0]      sum_re, sum_im, xy_ext;
    logic [Z_BITS-1:0]     new_re, new_im;
    logic                  esc_now;
    logic                  last_iter;

    // two's complement magnitude of a z component
    function automatic logic [Z_BITS-1:0] mag_z(input logic [Z_BITS-1:0] v);
        return v[Z_BITS-1] ? (~v + 1'b1) : v;
    endfunction

    // shift the exact product right and cap it
    function automatic logic [Z_BITS:0] cap_shift(input logic [PROD_W-1:0] p,
                                                  input int sh);
        logic [PROD_W-1:0] r;
        r = p >> sh;
        if (r > PROD_CAP)
        begin
            r = PROD_CAP;
        end
        return r[Z_BITS:0];
    endfunction

    // clamp a sum to the signed z range
    function automatic logic [Z_BITS-1:0] sat_z(input logic [SUM_W-1:0] s);
        logic [SUM_W-Z_BITS:0] top;
        top = s[SUM_W-1:Z_BITS-1];
        if ((&top) || !(|top))
        begin
            return s[Z_BITS-1:0];
        end
        return s[SUM_W-1] ? {1'b1, {(Z_BITS-1){1'b0}}} : {1'b0, {(Z_BITS-1){1'b1}}};
    endfunction

    // operand magnitudes and the operand half for this cycle
    always_comb
    begin
        ax   = mag_z(z_re_reg);
        ay   = mag_z(z_im_reg);
        bx   = cmd.mul_hi ? ax[Z_BITS-1:HALF] : ax[HALF-1:0];
        by   = cmd.mul_hi ? ay[Z_BITS-1:HALF] : ay[HALF-1:0];
        m_xx = {{HALF{1'b0}}, ax} * {{Z_BITS{1'b0}}, bx};
        m_yy = {{HALF{1'b0}}, ay} * {{Z_BITS{1'b0}}, by};
        m_xy = {{HALF{1'b0}}, ax} * {{Z_BITS{1'b0}}, by};
    end

    // full products from the two partial products
    always_comb
    begin
        full_xx = {{HALF{1'b0}}, plo_xx_reg} + {phi_xx_reg, {HALF{1'b0}}};
        full_yy = {{HALF{1'b0}}, plo_yy_reg} + {phi_yy_reg, {HALF{1'b0}}};
        full_xy = {{HALF{1'b0}}, plo_xy_reg} + {phi_xy_reg, {HALF{1'b0}}};
    end

    // new z, saturation and escape test
    always_comb
    begin
        sum_re = {{(SUM_W-Z_BITS-1){1'b0}}, sq_xx_reg}
               - {{(SUM_W-Z_BITS-1){1'b0}}, sq_yy_reg}
               + {{(SUM_W-IN_W){k_re_reg[IN_W-1]}}, k_re_reg};
        xy_ext = {{(SUM_W-Z_BITS-1){1'b0}}, sq_xy_reg};
        if (z_re_reg[Z_BITS-1] ^ z_im_reg[Z_BITS-1])
        begin
            xy_ext = ~xy_ext + 1'b1;
        end
        sum_im    = xy_ext + {{(SUM_W-IN_W){k_im_reg[IN_W-1]}}, k_im_reg};
        new_re    = sat_z(sum_re);
        new_im    = sat_z(sum_im);
        esc_now   = (mag_z(new_re) > {{(Z_BITS-THR_W){1'b0}}, cfg.threshold})
                 || (mag_z(new_im) > {{(Z_BITS-THR_W){1'b0}}, cfg.threshold});
        last_iter = ({1'b0, iter_reg} + 1'b1) == {1'b0, cfg.max_iter};
    end

    assign stat.zero_lim = (cfg.max_iter == '0);
    assign stat.finish   = esc_now || last_iter;

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            iter_reg      <= '0;
            res_count_reg <= cfg.max_iter;
            res_esc_reg   <= 1'b0;
            if (cfg.julia_mode)
            begin
                z_re_reg <= {{(Z_BITS-IN_W){req.c_re[IN_W-1]}}, req.c_re};
                z_im_reg <= {{(Z_BITS-IN_W){req.c_im[IN_W-1]}}, req.c_im};
                k_re_reg <= cfg.julia_c_re;
                k_im_reg <= cfg.julia_c_im;
            end
            else
            begin
                z_re_reg <= '0;
                z_im_reg <= '0;
                k_re_reg <= req.c_re;
                k_im_reg <= req.c_im;
            end
        end
        if (cmd.mul_lo)
        begin
            plo_xx_reg <= m_xx;
            plo_yy_reg <= m_yy;
            plo_xy_reg <= m_xy;
        end
        if (cmd.mul_hi)
        begin
            phi_xx_reg <= m_xx;
            phi_yy_reg <= m_yy;
            phi_xy_reg <= m_xy;
        end
        if (cmd.acc)
        begin
            sq_xx_reg <= cap_shift(full_xx, FRAC_BITS);
            sq_yy_reg <= cap_shift(full_yy, FRAC_BITS);
            sq_xy_reg <= cap_shift(full_xy, FRAC_BITS - 1);
        end
        if (cmd.upd)
        begin
            z_re_reg <= new_re;
            z_im_reg <= new_im;
            iter_reg <= iter_reg + 1'b1;
            if (esc_now)
            begin
                res_count_reg <= iter_reg;
                res_esc_reg   <= 1'b1;
            end
        end
    end

    assign result.escape_count = res_count_reg;
    assign result.escaped      = res_esc_reg;

endmodule

FILE: sv/biomorph_escape_iterator_unit.sv
// ----------------------------------------------------------------------------
// biomorph_escape_iterator_unit: escape-time iterator, biomorph formula
// Each iteration runs low products, high products, accumulate and update
//   through the shared 40x20 multipliers of the datapath; a new request is
//   accepted only when idle, after the previous result has been pushed.
// Reset: asynchronous, active low; sequencer idle, output empty, config regs
//   at threshold 10.0, max_iter 256, Mandelbrot mode, Julia constant 0.
// ----------------------------------------------------------------------------
module biomorph_escape_iterator_unit
    import bei_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_item_t          in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output out_item_t         out_data,
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]  cfg_wdata
);

    cfg_t      cfg_reg;
    logic      out_valid_reg;
    out_item_t out_data_reg;
    cmd_t      cmd;
    stat_t     stat;
    out_item_t result;
    logic      push;
    logic      out_free;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold  <= THR_RESET;
            cfg_reg.max_iter   <= ITER_RESET;
            cfg_reg.julia_mode <= 1'b0;
            cfg_reg.julia_c_re <= '0;
            cfg_reg.julia_c_im <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_THRESHOLD: cfg_reg.threshold  <= cfg_wdata[THR_W-1:0];
                REG_MAX_ITER:  cfg_reg.max_iter   <= cfg_wdata[COUNT_BITS-1:0];
                REG_JULIA_EN:  cfg_reg.julia_mode <= cfg_wdata[0];
                REG_JULIA_RE:  cfg_reg.julia_c_re <= cfg_wdata[IN_W-1:0];
                REG_JULIA_IM:  cfg_reg.julia_c_im <= cfg_wdata[IN_W-1:0];
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    // output register
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // sequencer
    bei_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (in_valid),
        .req_ready (in_ready),
        .out_free  (out_free),
        .push      (push),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath
    bei_dpath u_dpath (
        .clk    (clk),
        .cmd    (cmd),
        .cfg    (cfg_reg),
        .req    (in_data),
        .stat   (stat),
        .result (result)
    );

endmodule
